[hdl/ultrasonic_scan_avoid_sequencer_assert.svh]
// Assertion macros shared by the ultrasonic scan and avoid sequencer modules.
`ifndef ULTRASONIC_SCAN_AVOID_SEQUENCER_ASSERT_SVH
`define ULTRASONIC_SCAN_AVOID_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define USAS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in %m");

// Next-cycle implication, disabled during reset.
`define USAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

`endif

[hdl/usas_pkg.sv]
// Shared constants and types of the ultrasonic scan and avoid sequencer.
package usas_pkg;

  localparam int ECHO_COUNT_BITS_DEF = 16;
  localparam int DELAY_BITS_DEF = 20;

  localparam int DIST_W = 13;
  localparam int POS_W = 8;
  localparam int MOT_W = 3;
  localparam int CFG_W = 20;
  localparam int CFG_IDX_W = 3;
  localparam int TRIG_W = 8;
  localparam int REM_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_NEAR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MID    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LONG   = 3'd5;

  localparam logic [DIST_W-1:0] NEAR_RST   = 13'd15;
  localparam logic [TRIG_W-1:0] TRIG_RST   = 8'd4;
  localparam logic [CFG_W-1:0]  SETTLE_RST = 20'd200000;
  localparam logic [CFG_W-1:0]  SHORT_RST  = 20'd100000;
  localparam logic [CFG_W-1:0]  MID_RST    = 20'd140000;
  localparam logic [CFG_W-1:0]  LONG_RST   = 20'd200000;

  localparam logic [POS_W-1:0] POS_RIGHT  = 8'd45;
  localparam logic [POS_W-1:0] POS_LEFT   = 8'd115;
  localparam logic [POS_W-1:0] POS_CENTRE = 8'd81;

  localparam logic [MOT_W-1:0] MOT_GO    = 3'd0;
  localparam logic [MOT_W-1:0] MOT_STOP  = 3'd1;
  localparam logic [MOT_W-1:0] MOT_RIGHT = 3'd2;
  localparam logic [MOT_W-1:0] MOT_LEFT  = 3'd3;
  localparam logic [MOT_W-1:0] MOT_BACK  = 3'd4;

  // Distance is count * 170 / 2000, which reduces to count * 17 / 200.
  localparam logic [REM_W-1:0] ECHO_STEP = 8'd17;
  localparam logic [REM_W-1:0] ECHO_DIV  = 8'd200;
  localparam logic [DIST_W-1:0] DIST_MAX = 13'd8191;

  typedef struct packed {
    logic              trig_level;
    logic [POS_W-1:0]  servo_position;
    logic              servo_power;
    logic [MOT_W-1:0]  motor_cmd;
    logic [DIST_W-1:0] distance_cm;
    logic              distance_valid;
    logic              obstacle_left;
    logic              obstacle_mid;
    logic              obstacle_right;
  } result_t;

  typedef struct packed {
    logic clear;
    logic start;
    logic count;
  } rng_ctrl_t;

endpackage

[hdl/ultrasonic_scan_avoid_sequencer.sv]
// Top level of the ultrasonic scan and avoid sequencer.
// Each request is one 5 us tick with the sampled echo level; the block takes one request
// every clock while in_stall is low and returns one result per request, registered on
// acceptance in a two-entry buffer, so in_stall rises only when both entries hold results.
// The phase, wait counter and echo counter advance once per accepted tick; distance is
// tracked incrementally as count*17/200 while the echo is high, so no divider is needed.
// Echo waits have no timeout. Configuration writes take effect on the next tick.
`include "ultrasonic_scan_avoid_sequencer_assert.svh"

module ultrasonic_scan_avoid_sequencer #(
  parameter int ECHO_COUNT_BITS = usas_pkg::ECHO_COUNT_BITS_DEF,
  parameter int DELAY_BITS = usas_pkg::DELAY_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [usas_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [usas_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               echo_level,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               trig_level,
  output logic [usas_pkg::POS_W-1:0]         servo_position,
  output logic                               servo_power,
  output logic [usas_pkg::MOT_W-1:0]         motor_cmd,
  output logic [usas_pkg::DIST_W-1:0]        distance_cm,
  output logic                               distance_valid,
  output logic                               obstacle_left,
  output logic                               obstacle_mid,
  output logic                               obstacle_right
);

  localparam logic [4:0] PH_TRIG_F    = 5'd0;
  localparam logic [4:0] PH_WAIT_F    = 5'd1;
  localparam logic [4:0] PH_ECHO_F    = 5'd2;
  localparam logic [4:0] PH_TRIG_R    = 5'd3;
  localparam logic [4:0] PH_WAIT_R    = 5'd4;
  localparam logic [4:0] PH_ECHO_R    = 5'd5;
  localparam logic [4:0] PH_TRIG_L    = 5'd6;
  localparam logic [4:0] PH_WAIT_L    = 5'd7;
  localparam logic [4:0] PH_ECHO_L    = 5'd8;
  localparam logic [4:0] PH_SETTLE_R  = 5'd9;
  localparam logic [4:0] PH_SETTLE_L  = 5'd10;
  localparam logic [4:0] PH_SETTLE_C  = 5'd11;
  localparam logic [4:0] PH_TURN_MID  = 5'd12;
  localparam logic [4:0] PH_TURN_RS   = 5'd13;
  localparam logic [4:0] PH_TURN_LS   = 5'd14;
  localparam logic [4:0] PH_BACK      = 5'd15;
  localparam logic [4:0] PH_TURN_LONG = 5'd16;

  logic [usas_pkg::DIST_W-1:0] near_limit_cm;
  logic [usas_pkg::TRIG_W-1:0] trig_ticks;
  logic [usas_pkg::CFG_W-1:0]  servo_settle_ticks;
  logic [usas_pkg::CFG_W-1:0]  turn_short_ticks;
  logic [usas_pkg::CFG_W-1:0]  turn_mid_ticks;
  logic [usas_pkg::CFG_W-1:0]  turn_long_ticks;

  logic [4:0]                  phase;
  logic [4:0]                  phase_next;
  logic [DELAY_BITS-1:0]       wait_counter;
  logic [DELAY_BITS-1:0]       wait_counter_next;
  logic [DELAY_BITS-1:0]       wait_inc;
  logic [DELAY_BITS-1:0]       lim;
  logic [usas_pkg::CFG_W-1:0]  lim_raw;
  logic                        lim_done;
  logic [2:0]                  obstacle_flags;
  logic [2:0]                  obstacle_flags_next;
  logic [usas_pkg::DIST_W-1:0] last_distance;
  logic [usas_pkg::DIST_W-1:0] last_distance_next;
  logic                        dist_valid_next;
  logic [usas_pkg::DIST_W-1:0] rng_dist;
  logic                        blocked;
  logic                        in_fire;
  usas_pkg::rng_ctrl_t         rng_ctrl;
  usas_pkg::result_t           res_next;
  usas_pkg::result_t           res_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_limit_cm <= usas_pkg::NEAR_RST;
      trig_ticks <= usas_pkg::TRIG_RST;
      servo_settle_ticks <= usas_pkg::SETTLE_RST;
      turn_short_ticks <= usas_pkg::SHORT_RST;
      turn_mid_ticks <= usas_pkg::MID_RST;
      turn_long_ticks <= usas_pkg::LONG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        usas_pkg::REG_NEAR: near_limit_cm <= cfg_data[usas_pkg::DIST_W-1:0];
        usas_pkg::REG_TRIG: trig_ticks <= cfg_data[usas_pkg::TRIG_W-1:0];
        usas_pkg::REG_SETTLE: servo_settle_ticks <= cfg_data;
        usas_pkg::REG_SHORT: turn_short_ticks <= cfg_data;
        usas_pkg::REG_MID: turn_mid_ticks <= cfg_data;
        usas_pkg::REG_LONG: turn_long_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_fire = in_valid && !in_stall;

  always_comb begin
    case (phase)
      PH_TRIG_F, PH_TRIG_R, PH_TRIG_L: lim_raw = usas_pkg::CFG_W'(trig_ticks);
      PH_SETTLE_R, PH_SETTLE_L, PH_SETTLE_C: lim_raw = servo_settle_ticks;
      PH_TURN_MID: lim_raw = turn_mid_ticks;
      PH_TURN_LONG: lim_raw = turn_long_ticks;
      default: lim_raw = turn_short_ticks;
    endcase
  end

  assign lim = DELAY_BITS'(lim_raw);
  assign wait_inc = wait_counter + 1'b1;
  assign lim_done = (wait_inc >= lim);
  assign blocked = (rng_dist != '0) && (rng_dist < near_limit_cm);

  always_comb begin
    phase_next = phase;
    wait_counter_next = wait_counter;
    obstacle_flags_next = obstacle_flags;
    last_distance_next = last_distance;
    rng_ctrl = '0;
    dist_valid_next = 1'b0;
    case (phase)
      PH_TRIG_F, PH_TRIG_R, PH_TRIG_L,
      PH_SETTLE_R, PH_SETTLE_L, PH_SETTLE_C,
      PH_TURN_MID, PH_TURN_RS, PH_TURN_LS, PH_BACK, PH_TURN_LONG: begin
        wait_counter_next = lim_done ? '0 : wait_inc;
        if (lim_done) begin
          case (phase)
            PH_TRIG_F, PH_TRIG_R, PH_TRIG_L: phase_next = phase + 5'd1;
            PH_SETTLE_R: phase_next = PH_TRIG_R;
            PH_SETTLE_L: phase_next = PH_TRIG_L;
            PH_SETTLE_C: begin
              obstacle_flags_next = 3'b000;
              case ({obstacle_flags[2], obstacle_flags[0]})
                2'b00: phase_next = PH_TURN_MID;
                2'b01: phase_next = PH_TURN_LS;
                2'b10: phase_next = PH_TURN_RS;
                default: phase_next = PH_BACK;
              endcase
            end
            PH_BACK: phase_next = PH_TURN_LONG;
            default: phase_next = PH_TRIG_F;
          endcase
        end
      end
      PH_WAIT_F, PH_WAIT_R, PH_WAIT_L: begin
        if (echo_level) begin
          rng_ctrl.start = 1'b1;
          phase_next = phase + 5'd1;
        end
      end
      PH_ECHO_F, PH_ECHO_R, PH_ECHO_L: begin
        if (echo_level) begin
          rng_ctrl.count = 1'b1;
        end else begin
          last_distance_next = rng_dist;
          dist_valid_next = 1'b1;
          rng_ctrl.clear = 1'b1;
          wait_counter_next = '0;
          case (phase)
            PH_ECHO_F: begin
              if (blocked) begin
                obstacle_flags_next[1] = 1'b1;
                phase_next = PH_SETTLE_R;
              end else begin
                phase_next = PH_TRIG_F;
              end
            end
            PH_ECHO_R: begin
              obstacle_flags_next[0] = blocked;
              phase_next = PH_SETTLE_L;
            end
            default: begin
              obstacle_flags_next[2] = blocked;
              phase_next = PH_SETTLE_C;
            end
          endcase
        end
      end
      default: begin
        phase_next = PH_TRIG_F;
        wait_counter_next = '0;
        rng_ctrl.clear = 1'b1;
      end
    endcase
  end

  always_comb begin
    res_next.trig_level = 1'b0;
    res_next.servo_position = usas_pkg::POS_CENTRE;
    res_next.servo_power = 1'b0;
    res_next.motor_cmd = usas_pkg::MOT_GO;
    case (phase_next)
      PH_TRIG_F: res_next.trig_level = 1'b1;
      PH_TRIG_R: begin
        res_next.trig_level = 1'b1;
        res_next.servo_position = usas_pkg::POS_RIGHT;
        res_next.motor_cmd = usas_pkg::MOT_STOP;
      end
      PH_WAIT_R, PH_ECHO_R: begin
        res_next.servo_position = usas_pkg::POS_RIGHT;
        res_next.motor_cmd = usas_pkg::MOT_STOP;
      end
      PH_TRIG_L: begin
        res_next.trig_level = 1'b1;
        res_next.servo_position = usas_pkg::POS_LEFT;
        res_next.motor_cmd = usas_pkg::MOT_STOP;
      end
      PH_WAIT_L, PH_ECHO_L: begin
        res_next.servo_position = usas_pkg::POS_LEFT;
        res_next.motor_cmd = usas_pkg::MOT_STOP;
      end
      PH_SETTLE_R: begin
        res_next.servo_position = usas_pkg::POS_RIGHT;
        res_next.servo_power = 1'b1;
        res_next.motor_cmd = usas_pkg::MOT_STOP;
      end
      PH_SETTLE_L: begin
        res_next.servo_position = usas_pkg::POS_LEFT;
        res_next.servo_power = 1'b1;
        res_next.motor_cmd = usas_pkg::MOT_STOP;
      end
      PH_SETTLE_C: begin
        res_next.servo_power = 1'b1;
        res_next.motor_cmd = usas_pkg::MOT_STOP;
      end
      PH_TURN_MID, PH_TURN_RS, PH_TURN_LONG: res_next.motor_cmd = usas_pkg::MOT_RIGHT;
      PH_TURN_LS: res_next.motor_cmd = usas_pkg::MOT_LEFT;
      PH_BACK: res_next.motor_cmd = usas_pkg::MOT_BACK;
      default: ;
    endcase
    res_next.distance_cm = last_distance_next;
    res_next.distance_valid = dist_valid_next;
    res_next.obstacle_left = obstacle_flags_next[2];
    res_next.obstacle_mid = obstacle_flags_next[1];
    res_next.obstacle_right = obstacle_flags_next[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TRIG_F;
      wait_counter <= '0;
      obstacle_flags <= 3'b000;
      last_distance <= '0;
    end else if (in_fire) begin
      phase <= phase_next;
      wait_counter <= wait_counter_next;
      obstacle_flags <= obstacle_flags_next;
      last_distance <= last_distance_next;
    end
  end

  usas_range #(
    .ECHO_COUNT_BITS(ECHO_COUNT_BITS)
  ) u_range (
    .clk(clk),
    .rst(rst),
    .ctrl(in_fire ? rng_ctrl : usas_pkg::rng_ctrl_t'('0)),
    .distance(rng_dist)
  );

  usas_skid u_skid (
    .clk(clk),
    .rst(rst),
    .push(in_fire),
    .push_data(res_next),
    .full(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(res_out)
  );

  assign trig_level = res_out.trig_level;
  assign servo_position = res_out.servo_position;
  assign servo_power = res_out.servo_power;
  assign motor_cmd = res_out.motor_cmd;
  assign distance_cm = res_out.distance_cm;
  assign distance_valid = res_out.distance_valid;
  assign obstacle_left = res_out.obstacle_left;
  assign obstacle_mid = res_out.obstacle_mid;
  assign obstacle_right = res_out.obstacle_right;

  `USAS_ASSERT_NEXT(a_idle_holds, clk, rst, !in_fire, $stable(phase) && $stable(wait_counter))
  `USAS_ASSERT_NEXT(a_flags_cleared, clk, rst, in_fire && phase == PH_SETTLE_C && lim_done, obstacle_flags == 3'b000)
  `USAS_ASSERT_IMPL(a_dvalid_from_echo, clk, rst, in_fire && res_next.distance_valid, phase == PH_ECHO_F || phase == PH_ECHO_R || phase == PH_ECHO_L)

endmodule

[hdl/usas_range.sv]
// Echo pulse counter that keeps a running quotient and remainder of the distance.
module usas_range #(
  parameter int ECHO_COUNT_BITS = usas_pkg::ECHO_COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  usas_pkg::rng_ctrl_t              ctrl,
  output logic [usas_pkg::DIST_W-1:0]      distance
);

  logic [ECHO_COUNT_BITS-1:0] echo_count;
  logic [ECHO_COUNT_BITS-1:0] quot;
  logic [usas_pkg::REM_W-1:0] rem;
  logic [usas_pkg::REM_W-1:0] rem_sum;

  // The quotient tracks floor(echo_count * 17 / 200) one step per tick.
  assign rem_sum = rem + usas_pkg::ECHO_STEP;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      echo_count <= '0;
      quot <= '0;
      rem <= '0;
    end else if (ctrl.start) begin
      echo_count <= ECHO_COUNT_BITS'(1);
      quot <= '0;
      rem <= usas_pkg::ECHO_STEP;
    end else if (ctrl.count) begin
      if (&echo_count) begin
        echo_count <= '0;
        quot <= '0;
        rem <= '0;
      end else begin
        echo_count <= echo_count + 1'b1;
        if (rem_sum >= usas_pkg::ECHO_DIV) begin
          rem <= rem_sum - usas_pkg::ECHO_DIV;
          quot <= quot + 1'b1;
        end else begin
          rem <= rem_sum;
        end
      end
    end
  end

  assign distance = (32'(quot) > 32'(usas_pkg::DIST_MAX)) ? usas_pkg::DIST_MAX
                                                          : usas_pkg::DIST_W'(quot);

endmodule

[hdl/usas_skid.sv]
// Two-entry result buffer that decouples the sequencer from the result consumer.
`include "ultrasonic_scan_avoid_sequencer_assert.svh"

module usas_skid (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  usas_pkg::result_t   push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output usas_pkg::result_t   out_data
);

  logic              skid_valid;
  usas_pkg::result_t skid_data;
  logic              pop;

  assign pop = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  `USAS_ASSERT_IMPL(a_skid_behind_out, clk, rst, skid_valid, out_valid)

endmodule
